// ===== hdl/mife_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mnemonic index generator.
// No dependencies; imported by every module under hdl except mife_checker.
package mife_pkg;

  localparam int unsigned ENTROPY_BITS = 128;
  localparam int unsigned CHECK_BITS   = 4;
  localparam int unsigned INDEX_BITS   = 11;
  localparam int unsigned NUMBER_BITS  = 4;
  localparam int unsigned WORD_COUNT   = 12;
  localparam int unsigned PHRASE_BITS  = ENTROPY_BITS + CHECK_BITS;

  localparam logic [NUMBER_BITS-1:0] LAST_NUMBER = NUMBER_BITS'(WORD_COUNT - 1);

  // SHA-256 padding words for a 16-byte message
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] LEN_WORD = 32'(ENTROPY_BITS);

  localparam logic [31:0] SHA_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // entropy (byte 0 in the top bits) followed by the checksum nibble
  typedef struct packed {
    logic [ENTROPY_BITS-1:0] entropy;
    logic [CHECK_BITS-1:0]   check;
  } phrase_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_ROUND,
    HS_PUSH
  } hs_state_t;

  typedef enum logic {
    EM_IDLE,
    EM_RUN
  } em_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/mife_hash.sv =====
`timescale 1ns / 1ps
// Front end: accepts entropy, runs one SHA-256 compression a round per cycle,
// and hands entropy plus checksum nibble to the queue. Uses mife_pkg.
module mife_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,
  output logic              push_valid,
  input  logic              push_ready,
  output mife_pkg::phrase_t push_data
);
  import mife_pkg::*;

  hs_state_t   state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [ENTROPY_BITS-1:0] ent_r;
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;

  logic        take;
  logic [31:0] sig0, sig1, w_new;
  logic [31:0] bs0, bs1, ch, maj, t1, t2;
  logic [31:0] word0;

  assign take = in_tvalid && in_tready;

  // message schedule window: w_r[0] is this round's word
  assign sig0  = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign sig1  = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + sig0 + w_r[9] + sig1;

  assign bs1 = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
  assign ch  = (e_r & f_r) ^ (~e_r & g_r);
  assign t1  = h_r + bs1 + ch + SHA_K[rnd_r] + w_r[0];
  assign bs0 = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
  assign maj = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
  assign t2  = bs0 + maj;

  assign word0 = SHA_H[0] + a_r;

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    in_tready  = 1'b0;
    push_valid = 1'b0;
    unique case (state_r)
      HS_IDLE: begin
        in_tready = 1'b1;
        rnd_nxt   = '0;
        if (in_tvalid) begin
          state_nxt = HS_ROUND;
        end
      end
      HS_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = HS_PUSH;
        end
      end
      HS_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = HS_IDLE;
        end
      end
      default: state_nxt = HS_IDLE;
    endcase
  end

  assign push_data.entropy = ent_r;
  assign push_data.check   = word0[31:28];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      // tdata low half is entropy_high; byte 0 leads the message
      ent_r   <= {in_tdata[63:0], in_tdata[127:64]};
      w_r[0]  <= in_tdata[63:32];
      w_r[1]  <= in_tdata[31:0];
      w_r[2]  <= in_tdata[127:96];
      w_r[3]  <= in_tdata[95:64];
      w_r[4]  <= PAD_WORD;
      for (int i = 5; i < 15; i++) begin
        w_r[i] <= '0;
      end
      w_r[15] <= LEN_WORD;
      a_r <= SHA_H[0]; b_r <= SHA_H[1]; c_r <= SHA_H[2]; d_r <= SHA_H[3];
      e_r <= SHA_H[4]; f_r <= SHA_H[5]; g_r <= SHA_H[6]; h_r <= SHA_H[7];
    end else if (state_r == HS_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      h_r <= g_r;
      g_r <= f_r;
      f_r <= e_r;
      e_r <= d_r + t1;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= a_r;
      a_r <= t1 + t2;
    end
  end

endmodule

// ===== hdl/mife_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of finished phrases between the hash front end and the emitter.
// Uses mife_pkg for the entry type.
module mife_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  mife_pkg::phrase_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mife_pkg::phrase_t pop_data
);
  import mife_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  phrase_t        mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/mife_emit.sv =====
`timescale 1ns / 1ps
// Back end: pops a phrase and shifts out twelve 11-bit indices, MSB first,
// through a registered output stage. Uses mife_pkg.
module mife_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  mife_pkg::phrase_t             pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mife_pkg::INDEX_BITS-1:0]  word_index,
  output logic [mife_pkg::NUMBER_BITS-1:0] word_number,
  output logic                          last_word
);
  import mife_pkg::*;

  em_state_t               state_r, state_nxt;
  logic [PHRASE_BITS-1:0]  bits_r, bits_nxt;
  logic [NUMBER_BITS-1:0]  num_r, num_nxt;
  logic                    vld_r, vld_nxt;
  logic                    load_out;
  logic [INDEX_BITS-1:0]   idx_r;
  logic [NUMBER_BITS-1:0]  onum_r;
  logic                    last_r;

  always_comb begin
    state_nxt = state_r;
    bits_nxt  = bits_r;
    num_nxt   = num_r;
    vld_nxt   = vld_r;
    pop_ready = 1'b0;
    load_out  = 1'b0;
    if (vld_r && out_ready) begin
      vld_nxt = 1'b0;
    end
    unique case (state_r)
      EM_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          bits_nxt  = pop_data;
          num_nxt   = '0;
          state_nxt = EM_RUN;
        end
      end
      EM_RUN: begin
        // output stage is free or drains this cycle
        if (!vld_r || out_ready) begin
          load_out = 1'b1;
          vld_nxt  = 1'b1;
          bits_nxt = bits_r << INDEX_BITS;
          num_nxt  = num_r + NUMBER_BITS'(1);
          if (num_r == LAST_NUMBER) begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      vld_r   <= 1'b0;
      num_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      num_r   <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    if (load_out) begin
      idx_r  <= bits_r[PHRASE_BITS-1 -: INDEX_BITS];
      onum_r <= num_r;
      last_r <= (num_r == LAST_NUMBER);
    end
  end

  assign out_valid   = vld_r;
  assign word_index  = idx_r;
  assign word_number = onum_r;
  assign last_word   = last_r;

endmodule

// ===== hdl/mnemonic_index_from_entropy.sv =====
`timescale 1ns / 1ps
// Top level of the mnemonic index generator: hash front end, phrase queue,
// index emitter. Depends on mife_pkg, mife_hash, mife_queue, mife_emit.
//
//  channel | dir | tdata bits                                   | tlast
//  in_     | in  | [63:0] entropy_high, [127:64] entropy_low    | -
//  out_    | out | [10:0] word_index, [14:11] word_number, [15]=0 | last_word
//
// Hashing runs accept, 64 rounds on one round unit, then push; a new item is taken
// only after the push of the last one, which waits while the queue is full.
// Each phrase leaves as 12 transfers, one per cycle when out_tready stays high.
// rst_n is synchronous; it empties the queue and drops out_tvalid.
// A stalled output holds its transfer; the front keeps hashing until the queue fills.
module mnemonic_index_from_entropy #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] entropy_high, [127:64] entropy_low
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // [10:0] word_index, [14:11] word_number, [15] zero
  output logic         out_tlast
);
  import mife_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop_ready;
  phrase_t push_data, pop_data;
  logic [INDEX_BITS-1:0]  word_index;
  logic [NUMBER_BITS-1:0] word_number;

  mife_hash u_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mife_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mife_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .word_index  (word_index),
    .word_number (word_number),
    .last_word   (out_tlast)
  );

  assign out_tdata = {1'b0, word_number, word_index};

endmodule

// ===== hdl/mife_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for mnemonic_index_from_entropy, bound to the top level.
// Depends on the top level's port list only.
module mife_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [15:0]  out_tdata,
  input logic         out_tlast
);

  // reset drops the output stage
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // the round unit is busy right after an input transfer
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input taken while hashing");

  // the last flag marks word twelve and nothing else; the pad bit is zero
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[14:11] == 4'd11)) && !out_tdata[15])
    else $error("tlast does not match word number");

  // after a non-final word the next one is numbered one higher
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid
    |-> out_tdata[14:11] == $past(out_tdata[14:11]) + 4'd1)
    else $error("word number out of sequence");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transfer changed");

endmodule

bind mnemonic_index_from_entropy mife_checker u_mife_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== bench/mnemonic_index_from_entropy_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mnemonic_index_from_entropy: streams 128-bit entropy items,
// predicts the twelve 11-bit word indices (SHA-256 checksum included) and checks each output.
// Depends on mife_pkg and the RTL under hdl.
module mnemonic_index_from_entropy_tb;
  import mife_pkg::*;

  localparam int RANDOM_ITEMS = 295;
  localparam int QUIET_TAIL   = 40;     // items at the end sent with no gaps on either side
  localparam int HOLD_CYCLES  = 600;    // long receiver stall, fills the phrase queue
  localparam int STALL_LIMIT  = 3000;   // cycles without any transfer before giving up
  localparam int MAX_PRINTS   = 40;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [INDEX_BITS-1:0]  index;
    logic [NUMBER_BITS-1:0] number;
    logic                   last;
  } word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic         out_tlast;

  mnemonic_index_from_entropy uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // entropy kept as {high, low}: byte 0 in bits 127:120
  logic [127:0] entropy_backlog [$];
  word_t        phrase_words [$];
  word_t        want;
  int n_items = 0;
  int n_taken = 0;
  int n_words = 0;
  int n_errors = 0;
  int stall_cycles = 0;

  // per-side gap control
  int  send_gap = 0, send_span = 0, send_rate = 0;
  int  recv_gap = 0, recv_span = 0, recv_rate = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  quiet;

  assign quiet = (n_taken >= n_items - QUIET_TAIL);

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // top nibble of the first SHA-256 digest word over the 16 entropy bytes
  function automatic logic [3:0] entropy_checksum(input logic [127:0] ent);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 4; i++) w[i] = ent[127 - 32*i -: 32];
    w[4] = 32'h8000_0000;
    for (int i = 5; i < 15; i++) w[i] = '0;
    w[15] = 32'd128;
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = 32'h6a09e667; b = 32'hbb67ae85; c = 32'h3c6ef372; d = 32'ha54ff53a;
    e = 32'h510e527f; f = 32'h9b05688c; g = 32'h1f83d9ab; h = 32'h5be0cd19;
    for (int i = 0; i < 64; i++) begin
      s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_CONST[i] + w[i];
      s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return 4'((32'h6a09e667 + a) >> 28);
  endfunction

  task automatic queue_phrase(input logic [127:0] ent);
    logic [131:0] phrase;
    word_t        wd;
    phrase = {ent, entropy_checksum(ent)};
    for (int k = 0; k < WORD_COUNT; k++) begin
      wd.index  = phrase[131 - INDEX_BITS*k -: INDEX_BITS];
      wd.number = NUMBER_BITS'(k);
      wd.last   = (wd.number == LAST_NUMBER);
      phrase_words.push_back(wd);
    end
  endtask

  task automatic log_mismatch(input string what);
    if (n_errors < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        queue_phrase({in_tdata[63:0], in_tdata[127:64]});
        n_taken++;
      end
      if (send_span == 0) begin
        send_rate = $urandom_range(0, 3);
        send_span = $urandom_range(50, 200);
      end else begin
        send_span--;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) < send_rate) begin
          send_gap = $urandom_range(1, 14) - 1;
          in_tvalid <= 1'b0;
        end else if (entropy_backlog.size() != 0) begin
          logic [127:0] ent;
          ent = entropy_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {ent[63:0], ent[127:64]};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_words++;
        if (phrase_words.size() == 0) begin
          log_mismatch($sformatf("word transfer %h with nothing pending", out_tdata));
        end else begin
          want = phrase_words.pop_front();
          if (out_tdata[10:0] !== want.index)
            log_mismatch($sformatf("word %0d: index %h, want %h",
                                   want.number, out_tdata[10:0], want.index));
          if (out_tdata[14:11] !== want.number)
            log_mismatch($sformatf("word number %0d, want %0d", out_tdata[14:11], want.number));
          if (out_tlast !== want.last)
            log_mismatch($sformatf("word %0d: tlast %b, want %b",
                                   want.number, out_tlast, want.last));
          if (out_tdata[15] !== 1'b0)
            log_mismatch($sformatf("word %0d: pad bit set", want.number));
        end
      end
      if (recv_span == 0) begin
        recv_rate = $urandom_range(0, 3);
        recv_span = $urandom_range(30, 150);
      end else begin
        recv_span--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_taken >= 20) begin
        // sender keeps offering while the output is blocked
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) < recv_rate) begin
        recv_gap = $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles with no transfer", stall_cycles);
      $display("mnemonic_index_from_entropy_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [63:0] hi, lo;
    int          pick;
    // directed: extremes, bit patterns, index boundaries
    entropy_backlog.push_back('0);
    entropy_backlog.push_back('1);
    entropy_backlog.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
    entropy_backlog.push_back({64'h0, 64'hffff_ffff_ffff_ffff});
    entropy_backlog.push_back({32{4'h5}});
    entropy_backlog.push_back({32{4'ha}});
    entropy_backlog.push_back(128'h1 << 127);
    entropy_backlog.push_back(128'h1);
    entropy_backlog.push_back(128'h1 << 64);
    entropy_backlog.push_back(128'h1 << 63);
    entropy_backlog.push_back(128'h1 << (127 - 10));
    entropy_backlog.push_back(128'h1 << (127 - 11));
    entropy_backlog.push_back(128'h000102030405060708090a0b0c0d0e0f);
    entropy_backlog.push_back(128'h0123456789abcdeffedcba9876543210);
    entropy_backlog.push_back({16{8'h80}});
    entropy_backlog.push_back({16{8'h0f}});
    entropy_backlog.push_back(128'h7fff_ffff_ffff_ffff_ffff_ffff_ffff_fffe);
    // top 11 bits set then all clear: first index max, rest minimal
    entropy_backlog.push_back({11'h7ff, 117'h0});
    // entropy part of the final index all ones, checksum alone decides its low four bits
    entropy_backlog.push_back({121'h0, 7'h7f});
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        hi = rand64();
        lo = rand64();
      end else if (pick < 8) begin
        // sparse or dense patterns
        hi = rand64() & rand64() & rand64();
        lo = rand64() & rand64() & rand64();
        if (pick == 7) begin
          hi = ~hi;
          lo = ~lo;
        end
      end else begin
        hi = {8{8'($urandom)}};
        lo = {8{8'($urandom)}};
      end
      entropy_backlog.push_back({hi, lo});
    end
    n_items = entropy_backlog.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_items) @(posedge clk);
    while (phrase_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d entropy items (%0d directed) and %0d word transfers, one long output stall",
             n_taken, n_items - RANDOM_ITEMS, n_words);
    $display("mismatches: %0d, words still pending: %0d", n_errors, phrase_words.size());
    if (n_errors == 0 && phrase_words.size() == 0) begin
      $display("mnemonic_index_from_entropy_tb: done, clean");
    end else begin
      $display("mnemonic_index_from_entropy_tb: done, errors");
    end
    $finish;
  end

endmodule
